// ----- src/lped_pkg.sv -----
// shared types, codes and decode tables for the listpack entry decoder
package lped_pkg;

	// result kinds
	localparam logic [1:0] KIND_INT      = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
	localparam logic [1:0] KIND_STR_DONE = 2'd2;
	localparam logic [1:0] KIND_STATUS   = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD_ENC = 3'd1;
	localparam logic [2:0] ST_BAD_LEN = 3'd2;
	localparam logic [2:0] ST_TRUNC   = 3'd3;
	localparam logic [2:0] ST_END     = 3'd4;

	// entry encodings
	localparam logic [3:0] EK_INT7  = 4'd0;
	localparam logic [3:0] EK_INT13 = 4'd1;
	localparam logic [3:0] EK_INT16 = 4'd2;
	localparam logic [3:0] EK_INT24 = 4'd3;
	localparam logic [3:0] EK_INT32 = 4'd4;
	localparam logic [3:0] EK_INT64 = 4'd5;
	localparam logic [3:0] EK_STR6  = 4'd6;
	localparam logic [3:0] EK_STR12 = 4'd7;
	localparam logic [3:0] EK_STR32 = 4'd8;

	// special first bytes
	localparam logic [7:0] BYTE_EOF   = 8'hFF;
	localparam logic [7:0] BYTE_STR32 = 8'hF0;
	localparam logic [7:0] BYTE_INT16 = 8'hF1;
	localparam logic [7:0] BYTE_INT64 = 8'hF4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [63:0] int_value;
		logic [7:0]         payload_byte;
		logic [31:0]        string_length;
		logic [2:0]         status;
	} out_item_t;

	// header bytes that follow the first byte
	function automatic logic [3:0] hdr_len(input logic [3:0] ek);
		logic [3:0] len;
		case (ek)
			EK_INT13: len = 4'd1;
			EK_INT16: len = 4'd2;
			EK_INT24: len = 4'd3;
			EK_INT32: len = 4'd4;
			EK_INT64: len = 4'd8;
			EK_STR12: len = 4'd1;
			EK_STR32: len = 4'd4;
			default:  len = 4'd0;
		endcase
		return len;
	endfunction

	// sign extension from the encoding's integer width
	function automatic logic [63:0] sign_ext(input logic [3:0] ek, input logic [63:0] acc);
		logic [63:0] v;
		case (ek)
			EK_INT13: v = {{51{acc[12]}}, acc[12:0]};
			EK_INT16: v = {{48{acc[15]}}, acc[15:0]};
			EK_INT24: v = {{40{acc[23]}}, acc[23:0]};
			EK_INT32: v = {{32{acc[31]}}, acc[31:0]};
			default:  v = acc;
		endcase
		return v;
	endfunction

endpackage

// ----- src/lped_stream_if.sv -----
// valid/ready stream channel carrying one item per handshake
interface lped_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- src/lped_core.sv -----
// entry parse state and per-byte decode logic
module lped_core #(
	parameter int MAX_BACKLEN_BYTES = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  lped_pkg::in_item_t   item,
	output logic                 res_valid,
	output lped_pkg::out_item_t  res
);
	localparam int BlcW = $clog2(MAX_BACKLEN_BYTES + 1);

	localparam logic [2:0] PH_FIRST   = 3'd0;
	localparam logic [2:0] PH_HEADER  = 3'd1;
	localparam logic [2:0] PH_PAYLOAD = 3'd2;
	localparam logic [2:0] PH_BACKLEN = 3'd3;
	localparam logic [2:0] PH_SKIP    = 3'd4;

	logic [2:0]      phase_q, phase_d;
	logic [3:0]      ek_q, ek_d;
	logic [3:0]      hleft_q, hleft_d;
	logic [63:0]     acc_q, acc_d;
	logic [31:0]     pleft_q, pleft_d;
	logic [34:0]     ecount_q, ecount_d;
	logic [34:0]     blv_q, blv_d;
	logic [BlcW-1:0] blc_q, blc_d;

	logic [7:0]      b;
	logic [34:0]     ecount_inc;
	logic [34:0]     blv_next;
	logic [BlcW-1:0] blc_next;
	logic [2:0]      lane;
	logic [63:0]     acc_hdr;
	logic [3:0]      hleft_dec;
	logic            first_ok;

	assign b          = item.data_byte;
	assign ecount_inc = ecount_q + 35'd1;
	assign blc_next   = blc_q + BlcW'(1);
	assign blv_next   = (|blv_q[34:28]) ? '1 : {blv_q[27:0], b[6:0]};
	assign lane       = 3'(lped_pkg::hdr_len(ek_q) - hleft_q);
	assign hleft_dec  = (hleft_q != 4'd0) ? hleft_q - 4'd1 : 4'd0;

	// header byte: big-endian for the short forms, little-endian lanes otherwise
	always_comb begin
		if (ek_q == lped_pkg::EK_INT13 || ek_q == lped_pkg::EK_STR12) begin
			acc_hdr = {acc_q[55:0], b};
		end else begin
			acc_hdr = acc_q | (64'(b) << {lane, 3'b000});
		end
	end

	// next state and result for one accepted byte
	always_comb begin
		phase_d   = phase_q;
		ek_d      = ek_q;
		hleft_d   = hleft_q;
		acc_d     = acc_q;
		pleft_d   = pleft_q;
		ecount_d  = ecount_q;
		blv_d     = blv_q;
		blc_d     = blc_q;
		res_valid = 1'b0;
		res       = '0;
		first_ok  = 1'b0;
		if (fire) begin
			unique case (phase_q)
				PH_FIRST: begin
					if (item.buffer_end) begin
						res_valid  = 1'b1;
						res.kind   = lped_pkg::KIND_STATUS;
						res.status = (b == lped_pkg::BYTE_EOF) ? lped_pkg::ST_END
						                                       : lped_pkg::ST_TRUNC;
					end else begin
						ecount_d = 35'd1;
						blv_d    = '0;
						blc_d    = '0;
						acc_d    = '0;
						hleft_d  = '0;
						pleft_d  = '0;
						first_ok = 1'b1;
						if (b == lped_pkg::BYTE_EOF) begin
							first_ok   = 1'b0;
							phase_d    = PH_SKIP;
							res_valid  = 1'b1;
							res.kind   = lped_pkg::KIND_STATUS;
							res.status = lped_pkg::ST_END;
						end else if (b[7] == 1'b0) begin
							ek_d  = lped_pkg::EK_INT7;
							acc_d = 64'(b);
						end else if (b[7:6] == 2'b10) begin
							ek_d  = lped_pkg::EK_STR6;
							acc_d = 64'(b[5:0]);
						end else if (b[7:5] == 3'b110) begin
							ek_d  = lped_pkg::EK_INT13;
							acc_d = 64'(b[4:0]);
						end else if (b[7:4] == 4'b1110) begin
							ek_d  = lped_pkg::EK_STR12;
							acc_d = 64'(b[3:0]);
						end else if (b == lped_pkg::BYTE_STR32) begin
							ek_d = lped_pkg::EK_STR32;
						end else if (b <= lped_pkg::BYTE_INT64) begin
							ek_d = lped_pkg::EK_INT16 + 4'(b - lped_pkg::BYTE_INT16);
						end else begin
							first_ok   = 1'b0;
							phase_d    = PH_SKIP;
							res_valid  = 1'b1;
							res.kind   = lped_pkg::KIND_STATUS;
							res.status = lped_pkg::ST_BAD_ENC;
						end
						if (first_ok) begin
							hleft_d = lped_pkg::hdr_len(ek_d);
							if (hleft_d != 4'd0) begin
								phase_d = PH_HEADER;
							end else if (ek_d >= lped_pkg::EK_STR6) begin
								pleft_d = acc_d[31:0];
								phase_d = (acc_d[31:0] == 32'd0) ? PH_BACKLEN : PH_PAYLOAD;
							end else begin
								phase_d = PH_BACKLEN;
							end
						end
					end
				end
				PH_HEADER, PH_PAYLOAD, PH_BACKLEN: begin
					if (item.buffer_end) begin
						phase_d    = PH_FIRST;
						res_valid  = 1'b1;
						res.kind   = lped_pkg::KIND_STATUS;
						res.status = lped_pkg::ST_TRUNC;
					end else begin
						ecount_d = ecount_inc;
						if (phase_q == PH_HEADER) begin
							hleft_d = hleft_dec;
							acc_d   = acc_hdr;
							if (hleft_dec == 4'd0) begin
								if (ek_q >= lped_pkg::EK_STR6) begin
									pleft_d = acc_hdr[31:0];
									phase_d = (acc_hdr[31:0] == 32'd0) ? PH_BACKLEN
									                                  : PH_PAYLOAD;
								end else begin
									acc_d   = lped_pkg::sign_ext(ek_q, acc_hdr);
									phase_d = PH_BACKLEN;
								end
							end
						end else if (phase_q == PH_PAYLOAD) begin
							pleft_d          = pleft_q - 32'd1;
							if (pleft_q == 32'd1) begin
								phase_d = PH_BACKLEN;
							end
							res_valid        = 1'b1;
							res.kind         = lped_pkg::KIND_PAYLOAD;
							res.payload_byte = b;
						end else begin
							blc_d = blc_next;
							blv_d = blv_next;
							if (b[7]) begin
								if (blc_next >= BlcW'(MAX_BACKLEN_BYTES)) begin
									phase_d    = PH_SKIP;
									res_valid  = 1'b1;
									res.kind   = lped_pkg::KIND_STATUS;
									res.status = lped_pkg::ST_BAD_LEN;
								end
							end else if (blv_next == 35'd0 || blv_next != ecount_inc) begin
								phase_d    = PH_SKIP;
								res_valid  = 1'b1;
								res.kind   = lped_pkg::KIND_STATUS;
								res.status = lped_pkg::ST_BAD_LEN;
							end else begin
								phase_d   = PH_FIRST;
								res_valid = 1'b1;
								if (ek_q >= lped_pkg::EK_STR6) begin
									res.kind          = lped_pkg::KIND_STR_DONE;
									res.string_length = acc_q[31:0];
								end else begin
									res.kind      = lped_pkg::KIND_INT;
									res.int_value = acc_q;
								end
							end
						end
					end
				end
				default: begin
					// skipping to the end of the buffer
					if (item.buffer_end) begin
						phase_d = PH_FIRST;
					end
				end
			endcase
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			ek_q     <= '0;
			hleft_q  <= '0;
			acc_q    <= '0;
			pleft_q  <= '0;
			ecount_q <= '0;
			blv_q    <= '0;
			blc_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			ek_q     <= ek_d;
			hleft_q  <= hleft_d;
			acc_q    <= acc_d;
			pleft_q  <= pleft_d;
			ecount_q <= ecount_d;
			blv_q    <= blv_d;
			blc_q    <= blc_d;
		end
	end

endmodule

// ----- src/lped_out_fifo.sv -----
// two-entry result buffer between the decode logic and the output channel
module lped_out_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lped_pkg::out_item_t  push_data,
	input  logic                 pop,
	output logic                 full,
	output logic                 not_empty,
	output lped_pkg::out_item_t  head
);
	lped_pkg::out_item_t mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem[rd_ptr_q];

	// item storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/listpack_entry_decoder.sv -----
// top level of the listpack entry decoder
// Takes the entry region of a listpack one byte per item and reports, per entry, a
// sign-extended integer or the string's payload bytes followed by a string-done item,
// plus status items for the terminator, bad encodings, bad back-lengths and truncation.
// Every input byte is decoded in the cycle it is accepted: the parse state registers and
// the per-byte decode logic turn one byte into at most one result, which is written into
// a two-entry output buffer. A new byte is accepted every cycle while that buffer is not
// full, so the sustained rate is one byte per cycle when the output side keeps up, and a
// result is registered in that buffer before it appears on the output.
module listpack_entry_decoder #(
	parameter int MAX_BACKLEN_BYTES = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	lped_stream_if.sink   in,
	lped_stream_if.source out
);
	logic                fire;
	logic                res_valid;
	lped_pkg::out_item_t res;
	logic                full;
	logic                not_empty;
	lped_pkg::out_item_t head;

	assign in.ready  = ~full;
	assign fire      = in.valid & ~full;
	assign out.valid = not_empty;
	assign out.data  = head;

	// byte decoder
	lped_core #(
		.MAX_BACKLEN_BYTES(MAX_BACKLEN_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (in.data),
		.res_valid(res_valid),
		.res      (res)
	);

	// result buffer
	lped_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.pop      (out.valid & out.ready),
		.full     (full),
		.not_empty(not_empty),
		.head     (head)
	);

endmodule

// ----- src/lped_checker.sv -----
// port-level checks for the listpack entry decoder and their binding
module lped_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input lped_pkg::out_item_t out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// data items always carry an ok status
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != lped_pkg::KIND_STATUS |->
		out_data.status == lped_pkg::ST_OK)
		else $error("data item with fault status");

	// status items never report ok
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == lped_pkg::KIND_STATUS |->
		out_data.status != lped_pkg::ST_OK)
		else $error("status item reports ok");

	// a payload byte item carries no integer or length
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == lped_pkg::KIND_PAYLOAD |->
		out_data.int_value == 64'sd0 && out_data.string_length == 32'd0)
		else $error("payload item has stray fields");

	// taking a result from a full buffer frees the input
	a_ready_frees: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_valid && out_ready |=> in_ready)
		else $error("input stayed blocked after a result was taken");

endmodule

bind listpack_entry_decoder lped_checker u_lped_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (in.ready),
	.out_valid(out.valid),
	.out_ready(out.ready),
	.out_data (out.data)
);
